>>> src/btpf_pkg.sv
// Package for the below-threshold peak finder: widths, reset values and the
// stage structure shared by the pipeline modules. No dependencies.
package btpf_pkg;

	// Longest contig before the position counter wraps to zero.
	localparam int unsigned MAX_LENGTH = 1048576;
	localparam int unsigned POS_W      = $clog2(MAX_LENGTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LENGTH - 1);

	// Fixed field widths of the channel payloads.
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned OUT_POS_W = 20;

	// Threshold value after reset.
	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = -16'sd3;

	// Registered input beat handed from the input stage to the tracker.
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_of_contig;
	} stage_t;

endpackage

>>> src/btpf_if.sv
// Channel interfaces for the below-threshold peak finder: sample beats in and
// peak beats out, each with a valid/ready handshake. Depends on btpf_pkg.
interface btpf_in_if
	import btpf_pkg::*;
	;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_of_contig;

	modport source (output valid, output sample, output last_of_contig, input ready);
	modport sink   (input valid, input sample, input last_of_contig, output ready);
endinterface

interface btpf_out_if
	import btpf_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [OUT_POS_W-1:0] peak_start;
	logic [OUT_POS_W-1:0] peak_stop;

	modport source (output valid, output peak_start, output peak_stop, input ready);
	modport sink   (input valid, input peak_start, input peak_stop, output ready);
endinterface

>>> src/btpf_input_stage.sv
// Input register of the peak finder: captures one sample beat per cycle while the tracker advances.
// Depends on btpf_pkg and btpf_in_if.
module btpf_input_stage
	import btpf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	btpf_in_if.sink         samples,
	input  logic            advance,
	output stage_t          stage
);

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic                       ready;

	// The register may take a new beat when empty or when its beat moves on.
	assign ready = !valid_s1 || advance;
	assign samples.ready = ready;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (ready && samples.valid) begin
			sample_s1 <= samples.sample;
			last_s1   <= samples.last_of_contig;
		end
	end

	assign stage.valid          = valid_s1;
	assign stage.sample         = sample_s1;
	assign stage.last_of_contig = last_s1;

endmodule

>>> src/btpf_tracker.sv
// Region and peak tracking of the peak finder with its result register.
// Depends on btpf_pkg and btpf_out_if.
module btpf_tracker
	import btpf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [SAMPLE_W-1:0] threshold,
	input  stage_t                     stage,
	output logic                       advance,
	btpf_out_if.source                 peaks
);

	logic [POS_W-1:0]           position_q;
	logic                       in_region_q;
	logic signed [SAMPLE_W-1:0] lowest_value_q;
	logic signed [SAMPLE_W-1:0] previous_value_q;
	logic [POS_W-1:0]           lowest_start_q;
	logic [POS_W-1:0]           lowest_stop_q;

	logic                       out_valid_q;
	logic [OUT_POS_W-1:0]       peak_start_q;
	logic [OUT_POS_W-1:0]       peak_stop_q;

	logic                       fire;
	logic                       below;
	logic                       emit;
	logic [POS_W-1:0]           prev_position;

	// A beat is processed when the result register is free or being emptied.
	assign advance = !out_valid_q || peaks.ready;
	assign fire    = advance && stage.valid;

	assign below         = stage.sample < threshold;
	assign emit          = !below && in_region_q;
	assign prev_position = (position_q == '0) ? POS_LAST : position_q - 1'b1;

	// Tracking state and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q       <= '0;
			in_region_q      <= 1'b0;
			lowest_value_q   <= '0;
			previous_value_q <= '0;
			lowest_start_q   <= '0;
			lowest_stop_q    <= '0;
		end else if (fire) begin
			if (stage.last_of_contig || emit) begin
				in_region_q      <= 1'b0;
				lowest_value_q   <= '0;
				previous_value_q <= '0;
				lowest_start_q   <= '0;
				lowest_stop_q    <= '0;
			end else if (below) begin
				in_region_q      <= 1'b1;
				previous_value_q <= stage.sample;
				if (stage.sample < lowest_value_q) begin
					lowest_value_q <= stage.sample;
					lowest_start_q <= position_q;
				end else if (previous_value_q < 0 && previous_value_q == lowest_value_q) begin
					lowest_stop_q <= prev_position;
				end
			end
			if (stage.last_of_contig || position_q == POS_LAST) begin
				position_q <= '0;
			end else begin
				position_q <= position_q + 1'b1;
			end
		end
	end

	// Result register flag: set by a closing region, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (peaks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			peak_start_q <= OUT_POS_W'(lowest_start_q);
			peak_stop_q  <= OUT_POS_W'(lowest_stop_q);
		end
	end

	assign peaks.valid      = out_valid_q;
	assign peaks.peak_start = peak_start_q;
	assign peaks.peak_stop  = peak_stop_q;

	// A closing region always leaves a result waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |=> out_valid_q)
		else $error("closing region produced no result");

	// Outside a region all tracking state sits at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_region_q |-> (lowest_value_q == '0 && previous_value_q == '0 &&
			lowest_start_q == '0 && lowest_stop_q == '0))
		else $error("tracking state not cleared outside a region");

	// The running lowest value never exceeds the last region sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_region_q |-> (lowest_value_q <= previous_value_q))
		else $error("lowest value above previous sample");

	// The last beat of a contig restarts position and tracking.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && stage.last_of_contig) |=> (position_q == '0 && !in_region_q))
		else $error("contig end did not reset state");

endmodule

>>> src/below_threshold_peak_finder_top.sv
// An accepted sample beat waits in the input register until the tracker processes it and loads its
// result into the result register, from which the peak beat is taken.
// Throughput: one sample beat per cycle while the peak channel takes its beats; a result
// held for an idle receiver stalls the sample channel until it is taken.
// Reset: arst_n clears position, region state and both valid flags, and sets
// the threshold to -3; payload registers are not reset.
// Top level of the peak finder. Depends on btpf_pkg, btpf_if, btpf_input_stage
// and btpf_tracker.
module below_threshold_peak_finder_top
	import btpf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [SAMPLE_W-1:0] cfg_wdata,
	btpf_in_if.sink             samples,
	btpf_out_if.source          peaks
);

	logic signed [SAMPLE_W-1:0] threshold_q;
	stage_t                     stage;
	logic                       advance;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= signed'(cfg_wdata);
		end
	end

	btpf_input_stage u_input_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.advance (advance),
		.stage   (stage)
	);

	btpf_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.stage     (stage),
		.advance   (advance),
		.peaks     (peaks)
	);

endmodule
